// ===== sv/frame_time_window_stats_defines.svh =====
// Assertion macros shared by the frame time window statistics RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FRAME_TIME_WINDOW_STATS_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATS_DEFINES_SVH

`ifndef SYNTHESIS
`define FTWS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("frame time window stats: assertion failed");
`define FTWS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frame time window stats: assertion failed");
`else
`define FTWS_ASSERT(lbl, clk, rstn, prop)
`define FTWS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/ftws_pkg.sv =====
// Constants, types and helpers for the frame time window statistics block.
// Depends on nothing; used by the top level.
package ftws_pkg;

  localparam int unsigned TIME_W     = 10;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned MIN_TIME   = 1;
  localparam int unsigned MAX_TIME   = 1000;

  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  typedef enum logic [1:0] {
    DIV_AVG   = 2'd0,
    DIV_BEST  = 2'd1,
    DIV_WORST = 2'd2
  } div_sel_e;

  function automatic logic [TIME_W-1:0] sat_time(input logic [FRAME_W-1:0] ms);
    logic [TIME_W-1:0] res;
    if (ms < FRAME_W'(MIN_TIME)) begin
      res = TIME_W'(MIN_TIME);
    end else if (ms > FRAME_W'(MAX_TIME)) begin
      res = TIME_W'(MAX_TIME);
    end else begin
      res = ms[TIME_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/ftws_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing; holds the frame time ring.
module ftws_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ftws_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on the assertion macros in frame_time_window_stats_defines.svh.
`include "frame_time_window_stats_defines.svh"

module ftws_div #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `FTWS_ASSERT(a_div_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `FTWS_ASSERT(a_div_busy_count, clk_i, rst_ni, busy_o |-> (cnt_q != '0))

endmodule

// ===== sv/frame_time_window_stats.sv =====
// Top level of the frame time window statistics block: sequencer, ring and accumulators.
// Depends on ftws_pkg, ftws_ram, ftws_div and frame_time_window_stats_defines.svh.
//
// Each request either clears the ring of the last HISTORY frame times or records one time,
// saturated to 1..1000 ms. The block then reads the ring back one entry per cycle from its
// RAM, summing it and tracking the shortest and longest entries, and finally runs three
// divisions (average rate, then 1000 over the shortest and over the longest time) one after
// another on a single bit-serial divider. The ring read and the divider take up most of the
// time of a request. One request is processed at a time; in_ready_o is high only while the
// block is idle, though a finished result may still be waiting at the output. Clearing uses
// per-entry valid bits, so it does not have to write each RAM entry.
`include "frame_time_window_stats_defines.svh"

module frame_time_window_stats
  import ftws_pkg::*;
#(
  parameter int unsigned HISTORY = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [FRAME_W-1:0]  frame_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TIME_W-1:0]   average_rate_o,
  output logic [TIME_W-1:0]   best_gap_o,
  output logic [TIME_W-1:0]   worst_gap_o
);

  localparam int unsigned AW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int unsigned NW = $clog2(HISTORY * MS_PER_SEC + 1);
  localparam logic [NW-1:0] HIST_MS = NW'(HISTORY * MS_PER_SEC);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_WALK     = 6'b000010,
    S_DRAIN    = 6'b000100,
    S_DIV_GO   = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_OUT      = 6'b100000
  } ftws_state_e;

  ftws_state_e       state_q, state_d;
  div_sel_e          sel_q, sel_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [HISTORY-1:0] valid_q, valid_d;
  logic              rd_vld_q, rd_vld_d;
  logic              ent_vld_q;
  logic [NW-1:0]     total_q, total_d;
  logic [TIME_W-1:0] min_q, min_d;
  logic [TIME_W-1:0] max_q, max_d;
  logic [TIME_W-1:0] avg_q, avg_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic [TIME_W-1:0] worst_q, worst_d;
  logic              out_valid_q, out_valid_d;
  logic [TIME_W-1:0] out_avg_q, out_best_q, out_worst_q;
  logic              load_out;

  logic              accept;
  logic              ram_we;
  logic [TIME_W-1:0] ram_wdata;
  logic [TIME_W-1:0] ram_rdata;
  logic [TIME_W-1:0] entry;

  logic              div_start;
  logic [NW-1:0]     div_dividend;
  logic [NW-1:0]     div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [NW-1:0]     div_quo;
  logic [TIME_W-1:0] quo_t;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ram_we     = accept && (action_i == ACT_RECORD);
  assign ram_wdata  = sat_time(frame_ms_i);
  assign entry      = ent_vld_q ? ram_rdata : TIME_W'(MIN_TIME);
  assign quo_t      = div_quo[TIME_W-1:0];
  assign div_start  = (state_q == S_DIV_GO);

  ftws_ram #(
    .Width (TIME_W),
    .Depth (HISTORY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (sel_q)
      DIV_AVG: begin
        div_dividend = HIST_MS;
        div_divisor  = total_q;
      end
      DIV_BEST: begin
        div_dividend = NW'(MS_PER_SEC);
        div_divisor  = NW'(min_q);
      end
      DIV_WORST: begin
        div_dividend = NW'(MS_PER_SEC);
        div_divisor  = NW'(max_q);
      end
      default: begin
        div_dividend = HIST_MS;
        div_divisor  = total_q;
      end
    endcase
  end

  ftws_div #(
    .W (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    slot_d      = slot_q;
    rd_addr_d   = rd_addr_q;
    valid_d     = valid_q;
    rd_vld_d    = 1'b0;
    total_d     = total_q;
    min_d       = min_q;
    max_d       = max_q;
    avg_d       = avg_q;
    best_d      = best_q;
    worst_d     = worst_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (rd_vld_q) begin
      total_d = total_q + NW'(entry);
      if (entry < min_q) begin
        min_d = entry;
      end
      if (entry > max_q) begin
        max_d = entry;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_CLEAR) begin
            valid_d = '0;
            slot_d  = '0;
          end else begin
            valid_d[slot_q] = 1'b1;
            slot_d = (slot_q == AW'(HISTORY - 1)) ? '0 : slot_q + 1'b1;
          end
          rd_addr_d = '0;
          total_d   = '0;
          min_d     = TIME_W'(MAX_TIME);
          max_d     = TIME_W'(MIN_TIME);
          sel_d     = DIV_AVG;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        rd_vld_d  = 1'b1;
        rd_addr_d = rd_addr_q + 1'b1;
        if (rd_addr_q == AW'(HISTORY - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (sel_q)
            DIV_AVG: begin
              avg_d   = quo_t;
              sel_d   = DIV_BEST;
              state_d = S_DIV_GO;
            end
            DIV_BEST: begin
              best_d  = quo_t - avg_q;
              sel_d   = DIV_WORST;
              state_d = S_DIV_GO;
            end
            default: begin
              worst_d = avg_q - quo_t;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= DIV_AVG;
      slot_q      <= '0;
      rd_addr_q   <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      slot_q      <= slot_d;
      rd_addr_q   <= rd_addr_d;
      valid_q     <= valid_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_vld_q <= valid_q[rd_addr_q];
    total_q   <= total_d;
    min_q     <= min_d;
    max_q     <= max_d;
    avg_q     <= avg_d;
    best_q    <= best_d;
    worst_q   <= worst_d;
    if (load_out) begin
      out_avg_q   <= avg_q;
      out_best_q  <= best_q;
      out_worst_q <= worst_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_rate_o = out_avg_q;
  assign best_gap_o     = out_best_q;
  assign worst_gap_o    = out_worst_q;

  `FTWS_ASSERT(a_ready_div_idle, clk_i, rst_ni, in_ready_o |-> !div_busy)
  `FTWS_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> !in_ready_o)
  `FTWS_ASSERT(a_walk_bounds, clk_i, rst_ni,
    (state_q == S_DIV_GO) |-> ((min_q <= max_q) && (total_q >= NW'(HISTORY))))
  `FTWS_ASSERT(a_out_rate_nonzero, clk_i, rst_ni, out_valid_o |-> (average_rate_o != '0))

endmodule
